// ===== src/dsfp_pkg.sv =====
// Shared types, codes and helpers for the DAW SysEx frame parser.
`default_nettype none

package dsfp_pkg;

	localparam int unsigned OpW    = 2;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned KindW  = 2;
	localparam int unsigned ColorW = 16;
	localparam int unsigned CntW   = 4;
	localparam int unsigned FlagW  = 3;
	localparam int unsigned CfgIdxW = 2;

	// item kinds on the input channel
	typedef enum logic [OpW-1:0] {
		OP_BYTE  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_CONT  = 2'd3
	} op_t;

	// result kinds on the output channel
	typedef enum logic [KindW-1:0] {
		KIND_COLOR     = 2'd0,
		KIND_VALUE     = 2'd1,
		KIND_LEVEL     = 2'd2,
		KIND_TRANSPORT = 2'd3
	} kind_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_COLOR_OP     = 2'd0,
		CFG_VALUE_OP     = 2'd1,
		CFG_LEVEL_OP     = 2'd2,
		CFG_TRANSPORT_OP = 2'd3
	} cfg_idx_t;

	localparam logic [ByteW-1:0] COLOR_OP_RST     = 8'h01;
	localparam logic [ByteW-1:0] VALUE_OP_RST     = 8'h02;
	localparam logic [ByteW-1:0] LEVEL_OP_RST     = 8'h03;
	localparam logic [ByteW-1:0] TRANSPORT_OP_RST = 8'h05;

	// transport flag bit positions
	localparam int unsigned FLAG_PLAY  = 0;
	localparam int unsigned FLAG_REC   = 1;
	localparam int unsigned FLAG_PAUSE = 2;

	// byte positions inside a message
	localparam logic [CntW-1:0] POS_CMD   = 4'd4;
	localparam logic [CntW-1:0] POS_TRACK = 4'd5;
	localparam logic [CntW-1:0] POS_BANK  = 4'd6;
	localparam logic [CntW-1:0] POS_PL0   = 4'd7;
	localparam logic [CntW-1:0] POS_PL1   = 4'd8;
	localparam logic [CntW-1:0] POS_PL2   = 4'd9;
	localparam logic [CntW-1:0] CNT_MAX   = 4'd15;

	// minimum message lengths
	localparam logic [CntW-1:0] LEN_MIN       = 4'd6;
	localparam logic [CntW-1:0] LEN_COLOR     = 4'd10;
	localparam logic [CntW-1:0] LEN_VALUE     = 4'd8;
	localparam logic [CntW-1:0] LEN_TRANSPORT = 4'd7;

	// expected manufacturer header
	function automatic logic [ByteW-1:0] hdr_byte(input logic [1:0] pos);
		logic [ByteW-1:0] b;
		begin
			case (pos)
				2'd0:    b = 8'hF0;
				2'd1:    b = 8'h00;
				2'd2:    b = 8'h21;
				2'd3:    b = 8'h7B;
				default: b = 8'h00;
			endcase
			return b;
		end
	endfunction

	function automatic logic [ColorW-1:0] to565(input logic [ByteW-1:0] r,
		input logic [ByteW-1:0] g, input logic [ByteW-1:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

`default_nettype wire

// ===== src/dsfp_chan_if.sv =====
// Valid/ready channel interfaces for parser input and result words.
`default_nettype none

interface dsfp_in_if;
	logic                        valid;
	logic                        ready;
	logic [dsfp_pkg::OpW-1:0]    op;
	logic [dsfp_pkg::ByteW-1:0]  byte_in;
	logic                        last;

	modport source (output valid, output op, output byte_in, output last, input ready);
	modport sink   (input valid, input op, input byte_in, input last, output ready);
endinterface

interface dsfp_out_if;
	logic                        valid;
	logic                        ready;
	logic [dsfp_pkg::KindW-1:0]  kind;
	logic [dsfp_pkg::ByteW-1:0]  track_number;
	logic [dsfp_pkg::ByteW-1:0]  bank_number;
	logic [dsfp_pkg::ColorW-1:0] color565;
	logic [dsfp_pkg::ByteW-1:0]  level_value;
	logic                        playing;
	logic                        recording;
	logic                        paused;

	modport source (output valid, output kind, output track_number, output bank_number,
		output color565, output level_value, output playing, output recording,
		output paused, input ready);
	modport sink   (input valid, input kind, input track_number, input bank_number,
		input color565, input level_value, input playing, input recording,
		input paused, output ready);
endinterface

`default_nettype wire

// ===== src/daw_sysex_frame_parser_top.sv =====
// Top level of the DAW SysEx frame parser: input register, parse logic, result register.
// A word accepted into the stage 1 input register is parsed there and, if it yields a
//   result, is captured in the result register that drives the output channel.
// Throughput: one input word per cycle unless output stalls; parsing is combinational.
// Reset (arst_n low, async): byte count 0, header flag set, stored bytes 0, transport
//   flags clear, opcodes at their defaults, both pipeline valids cleared.
`default_nettype none

module daw_sysex_frame_parser_top (
	input  wire                              clk,
	input  wire                              arst_n,
	dsfp_in_if.sink                          in_ch,
	dsfp_out_if.source                       out_ch,
	input  wire                              cfg_wr_en,
	input  wire [dsfp_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire [dsfp_pkg::ByteW-1:0]        cfg_data
);

	localparam int unsigned BW = dsfp_pkg::ByteW;
	localparam int unsigned CW = dsfp_pkg::CntW;

	// ---------------- configuration registers ----------------
	logic [BW-1:0] color_op_q, value_op_q, level_op_q, transport_op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_op_q     <= dsfp_pkg::COLOR_OP_RST;
			value_op_q     <= dsfp_pkg::VALUE_OP_RST;
			level_op_q     <= dsfp_pkg::LEVEL_OP_RST;
			transport_op_q <= dsfp_pkg::TRANSPORT_OP_RST;
		end else if (cfg_wr_en) begin
			case (dsfp_pkg::cfg_idx_t'(cfg_index))
				dsfp_pkg::CFG_COLOR_OP:     color_op_q     <= cfg_data;
				dsfp_pkg::CFG_VALUE_OP:     value_op_q     <= cfg_data;
				dsfp_pkg::CFG_LEVEL_OP:     level_op_q     <= cfg_data;
				dsfp_pkg::CFG_TRANSPORT_OP: transport_op_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: input register ----------------
	logic                 valid_s1;
	dsfp_pkg::op_t        op_s1;
	logic [BW-1:0]        byte_s1;
	logic                 last_s1;
	logic                 adv_s1;     // stage 1 word is consumed this cycle
	logic                 out_valid_q;

	// stage 1 moves on whenever the result register is free or being drained
	assign adv_s1      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_s1   <= dsfp_pkg::op_t'(in_ch.op);
			byte_s1 <= in_ch.byte_in;
			last_s1 <= in_ch.last;
		end
	end

	// ---------------- parser state ----------------
	logic [CW-1:0]                  cnt_q,   cnt_nx;
	logic                           hdr_ok_q, hdr_ok_nx;
	logic [BW-1:0]                  cmd_q,   cmd_nx;
	logic [BW-1:0]                  track_q, track_nx;
	logic [BW-1:0]                  bank_q,  bank_nx;
	logic [BW-1:0]                  pl0_q, pl1_q, pl2_q;
	logic [BW-1:0]                  pl0_nx, pl1_nx, pl2_nx;
	logic [dsfp_pkg::FlagW-1:0]     flags_q, flags_nx;

	// result of the word in stage 1
	logic                           res_vld;
	dsfp_pkg::kind_t                res_kind;
	logic [BW-1:0]                  res_track, res_bank, res_level;
	logic [dsfp_pkg::ColorW-1:0]    res_color;

	logic [CW-1:0] len;
	logic          hdr_pos;

	always_comb begin
		cnt_nx    = cnt_q;
		hdr_ok_nx = hdr_ok_q;
		cmd_nx    = cmd_q;
		track_nx  = track_q;
		bank_nx   = bank_q;
		pl0_nx    = pl0_q;
		pl1_nx    = pl1_q;
		pl2_nx    = pl2_q;
		flags_nx  = flags_q;
		res_vld   = 1'b0;
		res_kind  = dsfp_pkg::KIND_TRANSPORT;
		res_track = '0;
		res_bank  = '0;
		res_level = '0;
		res_color = '0;
		len       = (cnt_q == dsfp_pkg::CNT_MAX) ? dsfp_pkg::CNT_MAX : cnt_q + 4'd1;
		hdr_pos   = (cnt_q < dsfp_pkg::POS_CMD);

		case (op_s1)
			dsfp_pkg::OP_START, dsfp_pkg::OP_CONT: begin
				// realtime events leave a message in flight untouched
				flags_nx[dsfp_pkg::FLAG_PLAY]  = 1'b1;
				flags_nx[dsfp_pkg::FLAG_PAUSE] = 1'b0;
				res_vld = 1'b1;
			end
			dsfp_pkg::OP_STOP: begin
				flags_nx[dsfp_pkg::FLAG_PLAY]  = 1'b0;
				flags_nx[dsfp_pkg::FLAG_PAUSE] = 1'b0;
				res_vld = 1'b1;
			end
			default: begin
				// check a header byte, or store a later byte at its position
				if (hdr_pos) begin
					if (byte_s1 != dsfp_pkg::hdr_byte(cnt_q[1:0]))
						hdr_ok_nx = 1'b0;
				end else begin
					case (cnt_q)
						dsfp_pkg::POS_CMD:   cmd_nx   = byte_s1;
						dsfp_pkg::POS_TRACK: track_nx = byte_s1;
						dsfp_pkg::POS_BANK:  bank_nx  = byte_s1;
						dsfp_pkg::POS_PL0:   pl0_nx   = byte_s1;
						dsfp_pkg::POS_PL1:   pl1_nx   = byte_s1;
						dsfp_pkg::POS_PL2:   pl2_nx   = byte_s1;
						default: ;
					endcase
				end
				cnt_nx = len;

				// end of message: judge it using the just-updated bytes
				if (last_s1) begin
					if (hdr_ok_nx && len >= dsfp_pkg::LEN_MIN) begin
						res_track = track_nx;
						res_bank  = (len > dsfp_pkg::LEN_MIN) ? bank_nx : '0;
						if (cmd_nx == color_op_q) begin
							res_kind  = dsfp_pkg::KIND_COLOR;
							res_color = dsfp_pkg::to565(pl0_nx, pl1_nx, pl2_nx);
							res_vld   = (len >= dsfp_pkg::LEN_COLOR);
						end else if (cmd_nx == value_op_q) begin
							res_kind  = dsfp_pkg::KIND_VALUE;
							res_level = pl0_nx;
							res_vld   = (len >= dsfp_pkg::LEN_VALUE);
						end else if (cmd_nx == level_op_q) begin
							res_kind  = dsfp_pkg::KIND_LEVEL;
							res_level = bank_nx;
							res_vld   = (len >= dsfp_pkg::LEN_VALUE);
						end else if (cmd_nx == transport_op_q) begin
							res_kind  = dsfp_pkg::KIND_TRANSPORT;
							res_track = '0;
							res_bank  = '0;
							if (len >= dsfp_pkg::LEN_TRANSPORT) begin
								flags_nx = track_nx[dsfp_pkg::FlagW-1:0];
								res_vld  = 1'b1;
							end
						end
					end
					// next message starts fresh; stored bytes stay
					cnt_nx    = '0;
					hdr_ok_nx = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			hdr_ok_q <= 1'b1;
			cmd_q    <= '0;
			track_q  <= '0;
			bank_q   <= '0;
			pl0_q    <= '0;
			pl1_q    <= '0;
			pl2_q    <= '0;
			flags_q  <= '0;
		end else if (adv_s1) begin
			cnt_q    <= cnt_nx;
			hdr_ok_q <= hdr_ok_nx;
			cmd_q    <= cmd_nx;
			track_q  <= track_nx;
			bank_q   <= bank_nx;
			pl0_q    <= pl0_nx;
			pl1_q    <= pl1_nx;
			pl2_q    <= pl2_nx;
			flags_q  <= flags_nx;
		end
	end

	// ---------------- result register ----------------
	dsfp_pkg::kind_t             kind_q;
	logic [BW-1:0]               track_out_q, bank_out_q, level_out_q;
	logic [dsfp_pkg::ColorW-1:0] color_out_q;
	logic [dsfp_pkg::FlagW-1:0]  flags_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= res_vld;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_vld) begin
			kind_q      <= res_kind;
			track_out_q <= res_track;
			bank_out_q  <= res_bank;
			level_out_q <= res_level;
			color_out_q <= res_color;
			flags_out_q <= flags_nx;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.kind         = kind_q;
	assign out_ch.track_number = track_out_q;
	assign out_ch.bank_number  = bank_out_q;
	assign out_ch.color565     = color_out_q;
	assign out_ch.level_value  = level_out_q;
	assign out_ch.playing      = flags_out_q[dsfp_pkg::FLAG_PLAY];
	assign out_ch.recording    = flags_out_q[dsfp_pkg::FLAG_REC];
	assign out_ch.paused       = flags_out_q[dsfp_pkg::FLAG_PAUSE];

	// ---------------- assertions ----------------
	a_msg_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && op_s1 == dsfp_pkg::OP_BYTE && last_s1) |=> (cnt_q == '0 && hdr_ok_q))
		else $error("parser state not rearmed after final byte");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && op_s1 == dsfp_pkg::OP_STOP) |=>
		(out_valid_q && !out_ch.playing && !out_ch.paused))
		else $error("stop did not emit cleared flags");

	a_start_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (op_s1 == dsfp_pkg::OP_START || op_s1 == dsfp_pkg::OP_CONT)) |=>
		(out_valid_q && out_ch.playing && !out_ch.paused))
		else $error("start/continue did not emit play flags");

	a_transport_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == dsfp_pkg::KIND_TRANSPORT) |->
		(track_out_q == '0 && bank_out_q == '0 && color_out_q == '0 && level_out_q == '0))
		else $error("transport word carries nonzero payload");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(op_s1) && $stable(byte_s1)))
		else $error("stage 1 word lost while stalled");

endmodule

`default_nettype wire
